### design/m2q_pkg.sv
// Package for the matrix-to-quaternion block: word formats, derived widths,
// item types for both channels and for the internal work queue.
// No dependencies.
package m2q_pkg;

    localparam int FRAC_BITS = 14;
    localparam int WORD_BITS = 16;

    // Diagonal sums span one plus three words, so two extra bits hold them.
    localparam int SUM_BITS  = WORD_BITS + 2;
    // A positive sum shifted up by FRAC_BITS fits in WORD_BITS+FRAC_BITS+1 bits.
    localparam int ROOT_BITS = (WORD_BITS + FRAC_BITS + 2) / 2;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 3;
    localparam int ONE       = 1 << FRAC_BITS;

    // Width at which the halved root is compared against the saturation limit,
    // and the index of the last root stage.
    localparam int CMP_BITS  = (ROOT_BITS > WORD_BITS) ? ROOT_BITS - 1 : WORD_BITS - 1;
    localparam int LAST      = ROOT_BITS - 1;

    localparam int LANES     = 4;
    localparam int AXES      = 3;
    localparam int LANE_W    = 0;
    localparam int LANE_X    = 1;
    localparam int LANE_Y    = 2;
    localparam int LANE_Z    = 3;

    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

    localparam logic [WORD_BITS-2:0] MAG_MAX = '1;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] m_right_x;
        logic signed [WORD_BITS-1:0] m_right_y;
        logic signed [WORD_BITS-1:0] m_right_z;
        logic signed [WORD_BITS-1:0] m_up_x;
        logic signed [WORD_BITS-1:0] m_up_y;
        logic signed [WORD_BITS-1:0] m_up_z;
        logic signed [WORD_BITS-1:0] m_at_x;
        logic signed [WORD_BITS-1:0] m_at_y;
        logic signed [WORD_BITS-1:0] m_at_z;
    } t_mat;

    typedef struct packed {
        logic        [WORD_BITS-2:0] quat_w;
        logic signed [WORD_BITS-1:0] quat_x;
        logic signed [WORD_BITS-1:0] quat_y;
        logic signed [WORD_BITS-1:0] quat_z;
    } t_quat;

    // Work item: four radicands already clamped and scaled, and the signs
    // of the x, y and z parts (bit 0 is x).
    typedef struct packed {
        logic [LANES-1:0][RAD_BITS-1:0] rad;
        logic [AXES-1:0]                neg;
    } t_work;

endpackage

### design/m2q_if.sv
// Valid/ready channel interfaces for the matrix input and quaternion output.
// Depends on m2q_pkg.
interface m2q_in_if;
    import m2q_pkg::*;

    logic valid;
    logic ready;
    t_mat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface m2q_out_if;
    import m2q_pkg::*;

    logic  valid;
    logic  ready;
    t_quat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/m2q_front.sv
// Front end: accepts matrix items, forms the four clamped radicands and the
// three sign bits, and holds them in a register until the queue takes them.
// Depends on m2q_pkg and m2q_if.
module m2q_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    m2q_in_if.sink          i_mat,
    output logic            o_work_valid,
    input  logic            i_work_ready,
    output m2q_pkg::t_work  o_work
);
    import m2q_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  load;

    logic signed [SUM_BITS-1:0]  rx, uy, az, one_s;
    logic signed [SUM_BITS-1:0]  sum [LANES];
    logic signed [WORD_BITS:0]   dx, dy, dz;

    assign i_mat.ready = !r_valid || i_work_ready;
    assign load        = i_mat.valid && i_mat.ready;

    always_comb begin
        rx    = SUM_BITS'(i_mat.data.m_right_x);
        uy    = SUM_BITS'(i_mat.data.m_up_y);
        az    = SUM_BITS'(i_mat.data.m_at_z);
        one_s = SUM_BITS'(ONE);

        sum[LANE_W] = one_s + rx + uy + az;
        sum[LANE_X] = one_s + rx - uy - az;
        sum[LANE_Y] = one_s - rx + uy - az;
        sum[LANE_Z] = one_s - rx - uy + az;

        for (int l = 0; l < LANES; l++) begin
            // Non-positive sums give a zero magnitude.
            if (sum[l] > 0) begin
                n_work.rad[l] = RAD_BITS'(sum[l]) << FRAC_BITS;
            end else begin
                n_work.rad[l] = '0;
            end
        end

        dx = (WORD_BITS+1)'(i_mat.data.m_at_y)    - (WORD_BITS+1)'(i_mat.data.m_up_z);
        dy = (WORD_BITS+1)'(i_mat.data.m_right_z) - (WORD_BITS+1)'(i_mat.data.m_at_x);
        dz = (WORD_BITS+1)'(i_mat.data.m_up_x)    - (WORD_BITS+1)'(i_mat.data.m_right_y);
        n_work.neg = {dz[WORD_BITS], dy[WORD_BITS], dx[WORD_BITS]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_work_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_work <= n_work;
        end
    end

    assign o_work_valid = r_valid;
    assign o_work       = r_work;

endmodule

### design/m2q_queue.sv
// Short queue of work items between the front end and the root pipeline.
// Depends on m2q_pkg.
module m2q_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  m2q_pkg::t_work  i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output m2q_pkg::t_work  o_pop_data
);
    import m2q_pkg::*;

    t_work                     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr;
    logic [QUEUE_PTR_BITS-1:0] r_rd;
    logic [QUEUE_PTR_BITS:0]   r_count;
    logic                      push;
    logic                      pop;

    assign o_push_ready = r_count != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

### design/m2q_back.sv
// Back end: four-lane digit-by-digit square root, one result bit per stage,
// followed by halving, saturation, sign and the output register.
// Depends on m2q_pkg and m2q_if.
module m2q_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_work_valid,
    output logic            o_work_ready,
    input  m2q_pkg::t_work  i_work,
    m2q_out_if.source       o_quat
);
    import m2q_pkg::*;

    logic [ROOT_BITS-1:0] r_valid;
    logic [REM_BITS-1:0]  r_rem  [ROOT_BITS][LANES];
    logic [ROOT_BITS-1:0] r_root [ROOT_BITS][LANES];
    logic [RAD_BITS-1:0]  r_rad  [ROOT_BITS][LANES];
    logic [AXES-1:0]      r_neg  [ROOT_BITS];
    logic [REM_BITS-1:0]  n_rem  [ROOT_BITS][LANES];
    logic [ROOT_BITS-1:0] n_root [ROOT_BITS][LANES];
    logic [RAD_BITS-1:0]  n_rad  [ROOT_BITS][LANES];
    logic                 r_out_valid;
    t_quat                r_out;
    t_quat                n_out;
    logic                 en;

    // The whole pipeline moves unless a finished result is held at the output.
    assign en           = !r_out_valid || o_quat.ready;
    assign o_work_ready = en;

    always_comb begin
        logic [REM_BITS-1:0]  acc;
        logic [REM_BITS-1:0]  trial;
        logic [REM_BITS-1:0]  s_rem;
        logic [ROOT_BITS-1:0] s_root;
        logic [RAD_BITS-1:0]  s_rad;
        for (int s = 0; s < ROOT_BITS; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    s_rem  = '0;
                    s_root = '0;
                    s_rad  = i_work.rad[l];
                end else begin
                    s_rem  = r_rem[s-1][l];
                    s_root = r_root[s-1][l];
                    s_rad  = r_rad[s-1][l];
                end
                // Bring down the next pair of radicand bits and try root*4+1.
                acc   = {s_rem[REM_BITS-3:0], s_rad[RAD_BITS-1 -: 2]};
                trial = {{(REM_BITS-ROOT_BITS-2){1'b0}}, s_root, 2'b01};
                if (acc >= trial) begin
                    n_rem[s][l]  = acc - trial;
                    n_root[s][l] = {s_root[ROOT_BITS-2:0], 1'b1};
                end else begin
                    n_rem[s][l]  = acc;
                    n_root[s][l] = {s_root[ROOT_BITS-2:0], 1'b0};
                end
                n_rad[s][l] = s_rad << 2;
            end
        end
    end

    always_comb begin
        logic [CMP_BITS-1:0]  ext;
        logic [WORD_BITS-2:0] mag [LANES];
        logic [WORD_BITS-1:0] sv;
        logic [WORD_BITS-1:0] sgn [AXES];
        for (int l = 0; l < LANES; l++) begin
            ext = CMP_BITS'(r_root[LAST][l][ROOT_BITS-1:1]);
            if (ext > CMP_BITS'(MAG_MAX)) begin
                mag[l] = MAG_MAX;
            end else begin
                mag[l] = (WORD_BITS-1)'(ext);
            end
        end
        for (int a = 0; a < AXES; a++) begin
            sv = {1'b0, mag[a+1]};
            if (r_neg[LAST][a]) begin
                sgn[a] = WORD_BITS'(0) - sv;
            end else begin
                sgn[a] = sv;
            end
        end
        n_out.quat_w = mag[LANE_W];
        n_out.quat_x = sgn[LANE_X-1];
        n_out.quat_y = sgn[LANE_Y-1];
        n_out.quat_z = sgn[LANE_Z-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_valid     <= {r_valid[ROOT_BITS-2:0], i_work_valid};
            r_out_valid <= r_valid[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_neg[0] <= i_work.neg;
            for (int s = 1; s < ROOT_BITS; s++) begin
                r_neg[s] <= r_neg[s-1];
            end
            r_out <= n_out;
        end
    end

    assign o_quat.valid = r_out_valid;
    assign o_quat.data  = r_out;

endmodule

### design/matrix_to_quaternion.sv
// Top level of the rotation-matrix to quaternion block.
// Depends on m2q_pkg, m2q_if, m2q_front, m2q_queue and m2q_back.
//
// Usage:
//   i_mat carries one 3x3 matrix per item (nine signed Q1.14 words); o_quat
//   carries the matching quaternion (w unsigned, x/y/z signed, same grid).
//   Both channels use valid/ready; an item moves when both are high.
//   Throughput is one item per cycle while the receiver keeps ready high.
//   From input acceptance to the result being offered, an item passes the
//   front register, the queue, the square-root pipeline, which resolves one
//   root bit per stage, and the output register.
//   Results leave in the order the matrices arrived.
//   When the receiver stalls, the root pipeline freezes with its result held
//   in the output register; the front end keeps accepting items until the
//   four-entry queue and its own register are full, then drops ready.
//   Reset clears all valid flags and queue pointers; no item is in flight
//   afterwards. The block keeps no state between items.
module matrix_to_quaternion (
    input  logic  i_clk,
    input  logic  i_rst_n,
    m2q_in_if.sink    i_mat,
    m2q_out_if.source o_quat
);
    import m2q_pkg::*;

    logic  w_front_valid;
    logic  w_q_push_ready;
    t_work w_front_work;
    logic  w_q_pop_valid;
    logic  w_back_ready;
    t_work w_q_work;

    m2q_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mat        (i_mat),
        .o_work_valid (w_front_valid),
        .i_work_ready (w_q_push_ready),
        .o_work       (w_front_work)
    );

    m2q_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_q_push_ready),
        .i_push_data  (w_front_work),
        .o_pop_valid  (w_q_pop_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_data   (w_q_work)
    );

    m2q_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (w_q_pop_valid),
        .o_work_ready (w_back_ready),
        .i_work       (w_q_work),
        .o_quat       (o_quat)
    );

    // The input only stalls when the front register is full and the queue is full.
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_mat.ready |-> (w_front_valid && !w_q_push_ready))
        else $error("input stalled while the queue had room");

    // A held result must freeze the root pipeline and stop queue reads.
    a_back_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_quat.valid && !o_quat.ready) |-> !w_back_ready)
        else $error("root pipeline advanced under a stalled output");

    // Saturation is symmetric, so no signed part reaches the most negative code.
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> (o_quat.data.quat_x != {1'b1, {(WORD_BITS-1){1'b0}}} &&
                          o_quat.data.quat_y != {1'b1, {(WORD_BITS-1){1'b0}}} &&
                          o_quat.data.quat_z != {1'b1, {(WORD_BITS-1){1'b0}}}))
        else $error("quaternion part reached the most negative code");

endmodule
